// ===== rtl/core/tmi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared constants, codes and types for the tempo map tick interpolator.
// ----------------------------------------------------------------------------
package tmi_pkg;

    localparam int MAX_MARKERS_DEF    = 4096;
    localparam int TICKS_PER_BEAT_DEF = 1920;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam int MODE_W  = 2;
    localparam int TIME_W  = 32;
    localparam int DEN_W   = 8;
    localparam int TICK_W  = 31;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 48;

    // shared unit widths: product of a position and a time difference
    localparam int UNIT_W  = POS_W + TIME_W;
    localparam int UNIT_DW = DEN_W + TIME_W;
    localparam int UNIT_CW = $clog2(UNIT_W);

    localparam logic [DEN_W-1:0] DEN_RESET = DEN_W'(4);
    localparam logic [UNIT_W-1:0] RATE_NUM = UNIT_W'(240000000);

    localparam logic [MODE_W-1:0] MODE_SIG    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARKER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    localparam logic KIND_TEMPO = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd3;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/tmi_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_in_if
// Request channel: signature changes, beat markers and time queries.
// ----------------------------------------------------------------------------
interface tmi_in_if;
    logic                         valid;
    logic                         ready;
    logic [tmi_pkg::MODE_W-1:0]   mode;
    logic [tmi_pkg::TIME_W-1:0]   time_ms;
    logic [tmi_pkg::DEN_W-1:0]    denominator;

    modport source (output valid, output mode, output time_ms, output denominator,
                    input ready);
    modport sink   (input valid, input mode, input time_ms, input denominator,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tmi_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_out_if
// Result channel: tempo entries and query answers.
// ----------------------------------------------------------------------------
interface tmi_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [tmi_pkg::TICK_W-1:0]   tick;
    logic [tmi_pkg::TICK_W-1:0]   tempo_rate;
    logic [tmi_pkg::STAT_W-1:0]   status;

    modport source (output valid, output kind, output tick, output tempo_rate,
                    output status, input ready);
    modport sink   (input valid, input kind, input tick, input tempo_rate,
                    input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tmi_shared_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_shared_unit
// Bit-serial shift-add multiplier and restoring divider sharing one register set.
// ----------------------------------------------------------------------------
module tmi_shared_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tmi_pkg::unit_req_t           req,
    input  wire logic [tmi_pkg::UNIT_W-1:0]   opa,
    input  wire logic [tmi_pkg::UNIT_DW-1:0]  opb,
    output tmi_pkg::unit_rsp_t                rsp,
    output logic [tmi_pkg::UNIT_W-1:0]        quot,
    output logic [tmi_pkg::UNIT_DW-1:0]       rem
);
    localparam int W  = tmi_pkg::UNIT_W;
    localparam int DW = tmi_pkg::UNIT_DW;
    localparam int CW = tmi_pkg::UNIT_CW;
    localparam logic [CW-1:0] MUL_LAST = CW'(tmi_pkg::TIME_W - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(W - 1);

    logic [W-1:0]  acc_reg,  acc_next;
    logic [W-1:0]  aux_reg,  aux_next;
    logic [DW-1:0] rem_reg,  rem_next;
    logic [DW-1:0] opb_reg,  opb_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          op_reg,   op_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          last;

    always_comb
    begin
        trial     = {rem_reg, acc_reg[W-1]};
        diff      = trial - {1'b0, opb_reg};
        last      = (op_reg == tmi_pkg::OP_DIV) ? (cnt_reg == DIV_LAST)
                                                : (cnt_reg == MUL_LAST);
        acc_next  = acc_reg;
        aux_next  = aux_reg;
        rem_next  = rem_reg;
        opb_next  = opb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            opb_next  = opb;
            rem_next  = '0;
            if (req.op == tmi_pkg::OP_DIV)
            begin
                acc_next = opa;
            end
            else
            begin
                acc_next = '0;
                aux_next = opa;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (op_reg == tmi_pkg::OP_DIV)
            begin
                if (!diff[DW])
                begin
                    rem_next = diff[DW-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DW-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (opb_reg[0])
                begin
                    acc_next = acc_reg + aux_reg;
                end
                aux_next = {aux_reg[W-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[DW-1:1]};
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= tmi_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        aux_reg <= aux_next;
        rem_reg <= rem_next;
        opb_reg <= opb_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quot     = acc_reg;
    assign rem      = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/core/tempo_map_ms_to_tick_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tempo_map_ms_to_tick_interp
// Beat-marker tempo map builder with millisecond to tick interpolation.
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | role
//  item    | in  | mode, time_ms, denominator            | sig / marker / query
//  result  | out | kind, tick, tempo_rate, status        | tempo entry / answer
//
//  Signature change, first marker and unused mode are handled in the idle
//  state. A later marker runs two 80-step divides in the shared unit, one on
//  a zero interval; a query runs a binary search over the marker memory,
//  then a 32-step multiply and an 80-step divide in the shared unit.
//  Reset zeroes count and running position and sets both denominators to 4;
//  memories are not cleared. A stalled result holds the sequencer at its
//  final step only.
// ----------------------------------------------------------------------------
module tempo_map_ms_to_tick_interp #(
    parameter int MAX_MARKERS    = tmi_pkg::MAX_MARKERS_DEF,
    parameter int TICKS_PER_BEAT = tmi_pkg::TICKS_PER_BEAT_DEF,
    parameter int FRACTION_BITS  = tmi_pkg::FRACTION_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tmi_in_if.sink     item,
    tmi_out_if.source  result
);
    localparam int W      = tmi_pkg::UNIT_W;
    localparam int DW     = tmi_pkg::UNIT_DW;
    localparam int POS_W  = tmi_pkg::POS_W;
    localparam int TIME_W = tmi_pkg::TIME_W;
    localparam int DEN_W  = tmi_pkg::DEN_W;
    localparam int TICK_W = tmi_pkg::TICK_W;
    localparam int STAT_W = tmi_pkg::STAT_W;
    localparam int IDX_W  = $clog2(MAX_MARKERS);
    localparam int CNT_W  = $clog2(MAX_MARKERS + 1);

    // step numerator: four beats in fixed point
    localparam logic [W-1:0] STEP_NUM = W'(64'(4 * TICKS_PER_BEAT) << FRACTION_BITS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MARKERS);
    localparam logic [POS_W-1:0] POS_SAT = '1;
    localparam logic [TICK_W-1:0] TICK_SAT = '1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_STEP  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_RATE  = 4'd3;
    localparam logic [3:0] ST_WRITE = 4'd4;
    localparam logic [3:0] ST_SRD   = 4'd5;
    localparam logic [3:0] ST_SCMP  = 4'd6;
    localparam logic [3:0] ST_RA    = 4'd7;
    localparam logic [3:0] ST_RB    = 4'd8;
    localparam logic [3:0] ST_RC    = 4'd9;
    localparam logic [3:0] ST_QMUL  = 4'd10;
    localparam logic [3:0] ST_QDIV  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    // marker memories
    logic [TIME_W-1:0] times_mem [MAX_MARKERS];
    logic [POS_W-1:0]  pos_mem   [MAX_MARKERS];
    logic [TIME_W-1:0] t_rd_reg;
    logic [POS_W-1:0]  p_rd_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] wr_time;
    logic [POS_W-1:0]  wr_pos;

    logic [3:0]        state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [DEN_W-1:0]  cur_den_reg, cur_den_next;
    logic [DEN_W-1:0]  last_den_reg, last_den_next;
    logic [POS_W-1:0]  run_pos_reg, run_pos_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;

    logic [TIME_W-1:0] time_reg,  time_next;
    logic [TIME_W-1:0] dt_reg,    dt_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [DW-1:0]     prod_reg,  prod_next;
    logic [CNT_W-1:0]  lo_reg,    lo_next;
    logic [CNT_W-1:0]  hi_reg,    hi_next;
    logic [CNT_W-1:0]  mid_reg,   mid_next;
    logic [TIME_W-1:0] ta_reg,    ta_next;
    logic [POS_W-1:0]  pa_reg,    pa_next;
    logic [TIME_W-1:0] span_reg,  span_next;

    logic              res_kind_reg,   res_kind_next;
    logic [TICK_W-1:0] res_tick_reg,   res_tick_next;
    logic [TICK_W-1:0] res_rate_reg,   res_rate_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [TICK_W-1:0] out_tick_reg;
    logic [TICK_W-1:0] out_rate_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_load;

    tmi_pkg::unit_req_t unit_req;
    tmi_pkg::unit_rsp_t unit_rsp;
    logic [W-1:0]       unit_a;
    logic [DW-1:0]      unit_b;
    logic [W-1:0]       unit_q;
    logic [DW-1:0]      unit_r;

    logic [POS_W:0]    pos_sum;
    logic [CNT_W-1:0]  mid_calc;
    logic [POS_W-1:0]  sub_val;
    logic [POS_W-1:0]  q_pos;

    function automatic logic [TICK_W-1:0] to_tick(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] sh;
        sh = p >> FRACTION_BITS;
        to_tick = (sh > POS_W'(TICK_SAT)) ? TICK_SAT : sh[TICK_W-1:0];
    endfunction

    tmi_shared_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .opa   (unit_a),
        .opb   (unit_b),
        .rsp   (unit_rsp),
        .quot  (unit_q),
        .rem   (unit_r)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        pos_sum  = {1'b0, run_pos_reg} + {1'b0, unit_q[POS_W-1:0]};
        mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
        q_pos    = unit_q[POS_W-1:0];
        sub_val  = q_pos + POS_W'(unit_r != '0);

        state_next      = state_reg;
        count_next      = count_reg;
        cur_den_next    = cur_den_reg;
        last_den_next   = last_den_reg;
        run_pos_next    = run_pos_reg;
        last_time_next  = last_time_reg;
        time_next       = time_reg;
        dt_next         = dt_reg;
        pos_next        = pos_reg;
        prod_next       = prod_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ta_next         = ta_reg;
        pa_next         = pa_reg;
        span_next       = span_reg;
        res_kind_next   = res_kind_reg;
        res_tick_next   = res_tick_reg;
        res_rate_next   = res_rate_reg;
        res_status_next = res_status_reg;

        unit_req.start = 1'b0;
        unit_req.op    = tmi_pkg::OP_DIV;
        unit_a         = '0;
        unit_b         = '0;
        rd_addr        = lo_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_time        = time_reg;
        wr_pos         = pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    case (item.mode)
                        tmi_pkg::MODE_SIG:
                        begin
                            if (item.denominator != '0)
                            begin
                                cur_den_next = item.denominator;
                            end
                        end
                        tmi_pkg::MODE_MARKER:
                        begin
                            if (count_reg >= CNT_MAX)
                            begin
                                res_kind_next   = tmi_pkg::KIND_TEMPO;
                                res_tick_next   = '0;
                                res_rate_next   = '0;
                                res_status_next = tmi_pkg::STAT_FULL;
                                state_next      = ST_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = '0;
                                wr_time        = item.time_ms;
                                wr_pos         = '0;
                                run_pos_next   = '0;
                                last_time_next = item.time_ms;
                                last_den_next  = cur_den_reg;
                                count_next     = CNT_W'(1);
                            end
                            else
                            begin
                                time_next      = item.time_ms;
                                dt_next        = item.time_ms - last_time_reg;
                                unit_req.start = 1'b1;
                                unit_req.op    = tmi_pkg::OP_DIV;
                                unit_a         = STEP_NUM;
                                unit_b         = DW'(last_den_reg);
                                state_next     = ST_STEP;
                            end
                        end
                        tmi_pkg::MODE_QUERY:
                        begin
                            time_next  = item.time_ms;
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = ST_SRD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                if (unit_rsp.done)
                begin
                    pos_next  = pos_sum[POS_W] ? POS_SAT : pos_sum[POS_W-1:0];
                    prod_next = DW'(last_den_reg) * DW'(dt_reg);
                    if (dt_reg == '0)
                    begin
                        res_rate_next   = '0;
                        res_status_next = tmi_pkg::STAT_ZERO;
                        state_next      = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                unit_req.start = 1'b1;
                unit_req.op    = tmi_pkg::OP_DIV;
                unit_a         = tmi_pkg::RATE_NUM;
                unit_b         = prod_reg;
                state_next     = ST_RATE;
            end
            ST_RATE:
            begin
                if (unit_rsp.done)
                begin
                    res_rate_next   = (unit_q > W'(TICK_SAT)) ? TICK_SAT
                                                               : unit_q[TICK_W-1:0];
                    res_status_next = tmi_pkg::STAT_OK;
                    state_next      = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                wr_en          = 1'b1;
                res_kind_next  = tmi_pkg::KIND_TEMPO;
                res_tick_next  = to_tick(run_pos_reg);
                run_pos_next   = pos_reg;
                last_time_next = time_reg;
                last_den_next  = cur_den_reg;
                count_next     = count_reg + CNT_W'(1);
                state_next     = ST_OUT;
            end
            ST_SRD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_SCMP;
                end
                else if (lo_reg == '0 || lo_reg >= count_reg)
                begin
                    res_kind_next   = tmi_pkg::KIND_QUERY;
                    res_tick_next   = '0;
                    res_rate_next   = '0;
                    res_status_next = tmi_pkg::STAT_RANGE;
                    state_next      = ST_OUT;
                end
                else
                begin
                    state_next = ST_RA;
                end
            end
            ST_SCMP:
            begin
                if (t_rd_reg <= time_reg)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRD;
            end
            ST_RA:
            begin
                rd_addr    = lo_reg[IDX_W-1:0];
                state_next = ST_RB;
            end
            ST_RB:
            begin
                ta_next    = t_rd_reg;
                pa_next    = p_rd_reg;
                rd_addr    = lo_next[IDX_W-1:0] - IDX_W'(1);
                state_next = ST_RC;
            end
            ST_RC:
            begin
                // product of position span and distance back from upper marker
                span_next      = ta_reg - t_rd_reg;
                unit_req.start = 1'b1;
                unit_req.op    = tmi_pkg::OP_MUL;
                unit_a         = W'(pa_reg - p_rd_reg);
                unit_b         = DW'(ta_reg - time_reg);
                state_next     = ST_QMUL;
            end
            ST_QMUL:
            begin
                if (unit_rsp.done)
                begin
                    unit_req.start = 1'b1;
                    unit_req.op    = tmi_pkg::OP_DIV;
                    unit_a         = unit_q;
                    unit_b         = DW'(span_reg);
                    state_next     = ST_QDIV;
                end
            end
            ST_QDIV:
            begin
                if (unit_rsp.done)
                begin
                    // ceiling of the quotient, taken off the upper position
                    res_kind_next   = tmi_pkg::KIND_QUERY;
                    res_tick_next   = to_tick(pa_reg - sub_val);
                    res_rate_next   = '0;
                    res_status_next = tmi_pkg::STAT_OK;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            times_mem[wr_addr] <= wr_time;
            pos_mem[wr_addr]   <= wr_pos;
        end
        t_rd_reg <= times_mem[rd_addr];
        p_rd_reg <= pos_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cur_den_reg   <= tmi_pkg::DEN_RESET;
            last_den_reg  <= tmi_pkg::DEN_RESET;
            run_pos_reg   <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_den_reg   <= cur_den_next;
            last_den_reg  <= last_den_next;
            run_pos_reg   <= run_pos_next;
            last_time_reg <= last_time_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg       <= time_next;
        dt_reg         <= dt_next;
        pos_reg        <= pos_next;
        prod_reg       <= prod_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ta_reg         <= ta_next;
        pa_reg         <= pa_next;
        span_reg       <= span_next;
        res_kind_reg   <= res_kind_next;
        res_tick_reg   <= res_tick_next;
        res_rate_reg   <= res_rate_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_kind_reg   <= res_kind_reg;
            out_tick_reg   <= res_tick_reg;
            out_rate_reg   <= res_rate_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = out_kind_reg;
    assign result.tick       = out_tick_reg;
    assign result.tempo_rate = out_rate_reg;
    assign result.status     = out_status_reg;
endmodule
`default_nettype wire

// ===== dv/tb_tempo_map_ms_to_tick_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tempo_map_ms_to_tick_interp
// Self-checking bench for the tempo map tick interpolator: a directed table of
// requests followed by random marker maps and queries, with every result
// checked against a built-in model of the tempo map and its interpolation.
// ----------------------------------------------------------------------------
module tb_tempo_map_ms_to_tick_interp;

    localparam int N_MARK = tmi_pkg::MAX_MARKERS_DEF;
    localparam int N_ROWS = 21;
    localparam logic [47:0] POS_SAT = 48'hFFFF_FFFF_FFFF;
    // mode code with no function; the block drops it
    localparam logic [tmi_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one row of the directed table; has_exp marks rows with a typed answer
    typedef struct {
        logic [tmi_pkg::MODE_W-1:0] mode;
        logic [31:0]                ms;
        logic [7:0]                 den;
        bit                         has_exp;
        logic [tmi_pkg::STAT_W-1:0] exp_status;
    } req_row_t;

    typedef struct packed {
        logic                       kind;
        logic [tmi_pkg::TICK_W-1:0] tick;
        logic [tmi_pkg::TICK_W-1:0] rate;
        logic [tmi_pkg::STAT_W-1:0] status;
    } answer_t;

    logic clk;
    logic rst_n;
    tmi_in_if  item ();
    tmi_out_if result ();

    tempo_map_ms_to_tick_interp i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    // ------------------------------------------------------------------
    // Tempo map model: mirrors the block's table and running position.
    // ------------------------------------------------------------------
    logic [31:0] map_time [N_MARK];
    logic [47:0] map_pos  [N_MARK];
    int unsigned map_count;
    logic [7:0]  cur_den;
    logic [7:0]  den_last;
    logic [47:0] run_pos;

    answer_t     answers_due [$];
    int          errors;
    bit          hold_long;

    function automatic logic [tmi_pkg::TICK_W-1:0] pos_tick(logic [47:0] p);
        logic [47:0] t;
        t = p >> tmi_pkg::FRACTION_BITS_DEF;
        return (t > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : t[30:0];
    endfunction

    function automatic void queue_answer(answer_t a);
        answers_due = {answers_due, a};
    endfunction

    // applies one accepted request; queues the answer it causes, if any
    task automatic model_request(logic [tmi_pkg::MODE_W-1:0] mode, logic [31:0] ms,
                                 logic [7:0] den);
        answer_t     a;
        logic [63:0] step, nxt, dt, rate, span, back, diff, q, r, prod, sub;
        int unsigned lo, hi, mid;
        a = '0;
        case (mode)
            tmi_pkg::MODE_SIG:
            begin
                if (den != 0) cur_den = den;
            end
            tmi_pkg::MODE_MARKER:
            begin
                if (map_count >= N_MARK)
                begin
                    a.kind = tmi_pkg::KIND_TEMPO; a.status = tmi_pkg::STAT_FULL;
                    queue_answer(a);
                end
                else if (map_count == 0)
                begin
                    map_time[0] = ms; map_pos[0] = '0; run_pos = '0;
                    den_last = cur_den; map_count = 1;
                end
                else
                begin
                    step = ((64'd4 * tmi_pkg::TICKS_PER_BEAT_DEF)
                            << tmi_pkg::FRACTION_BITS_DEF) / den_last;
                    nxt = {16'd0, run_pos} + step;
                    if (nxt > {16'd0, POS_SAT}) nxt = {16'd0, POS_SAT};
                    dt = {32'd0, ms - map_time[map_count-1]};
                    a.kind = tmi_pkg::KIND_TEMPO;
                    a.tick = pos_tick(run_pos);
                    if (dt == 0)
                        a.status = tmi_pkg::STAT_ZERO;
                    else
                    begin
                        rate = 64'd240000000 / (64'(den_last) * dt);
                        a.rate = (rate > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : rate[30:0];
                        a.status = tmi_pkg::STAT_OK;
                    end
                    map_time[map_count] = ms; map_pos[map_count] = nxt[47:0];
                    run_pos = nxt[47:0]; den_last = cur_den; map_count++;
                    queue_answer(a);
                end
            end
            tmi_pkg::MODE_QUERY:
            begin
                lo = 0; hi = map_count;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (map_time[mid] <= ms) lo = mid + 1; else hi = mid;
                end
                a.kind = tmi_pkg::KIND_QUERY;
                if (lo == 0 || lo >= map_count)
                    a.status = tmi_pkg::STAT_RANGE;
                else
                begin
                    span = {32'd0, map_time[lo] - map_time[lo-1]};
                    back = {32'd0, map_time[lo] - ms};
                    diff = {16'd0, map_pos[lo] - map_pos[lo-1]};
                    // ceil(diff*back/span) without overflowing 64 bits
                    q = diff / span; r = diff % span; prod = r * back;
                    sub = q * back + prod / span + ((prod % span != 0) ? 1 : 0);
                    a.tick = pos_tick(map_pos[lo] - sub[47:0]);
                    a.status = tmi_pkg::STAT_OK;
                end
                queue_answer(a);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: drives at falling edges, counts an accept at the rising edge.
    // ------------------------------------------------------------------
    int  sent;

    task automatic send(logic [tmi_pkg::MODE_W-1:0] mode, logic [31:0] ms,
                        logic [7:0] den);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.valid <= 1'b1; item.mode <= mode; item.time_ms <= ms; item.denominator <= den;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        model_request(mode, ms, den);
        sent++;
        @(negedge clk);
    endtask

    // directed rows: reset behavior, extremes, special cases other than a full map
    req_row_t dir_rows [N_ROWS] = '{
        '{tmi_pkg::MODE_QUERY,  32'd0,         8'd0,   1, tmi_pkg::STAT_RANGE}, // empty
        '{tmi_pkg::MODE_MARKER, 32'd1000,      8'd0,   0, tmi_pkg::STAT_OK},    // first
        '{tmi_pkg::MODE_QUERY,  32'd1000,      8'd0,   1, tmi_pkg::STAT_RANGE}, // one marker
        '{tmi_pkg::MODE_SIG,    32'd0,         8'd0,   0, tmi_pkg::STAT_OK},    // zero den
        '{MODE_UNUSED,          32'hFFFF_FFFF, 8'hFF,  0, tmi_pkg::STAT_OK},    // unused
        '{tmi_pkg::MODE_MARKER, 32'd1500,      8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_MARKER, 32'd1500,      8'd0,   1, tmi_pkg::STAT_ZERO},  // zero dt
        '{tmi_pkg::MODE_SIG,    32'd1500,      8'd255, 0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_MARKER, 32'd2000,      8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_SIG,    32'd2000,      8'd1,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_MARKER, 32'd2001,      8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_MARKER, 32'hFFFF_FFFF, 8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_QUERY,  32'd999,       8'd0,   1, tmi_pkg::STAT_RANGE}, // before
        '{tmi_pkg::MODE_QUERY,  32'd1250,      8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_QUERY,  32'd1999,      8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_QUERY,  32'd2001,      8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_QUERY,  32'h8000_0000, 8'd0,   0, tmi_pkg::STAT_OK},
        '{tmi_pkg::MODE_QUERY,  32'hFFFF_FFFF, 8'd0,   1, tmi_pkg::STAT_RANGE}, // at last
        '{tmi_pkg::MODE_MARKER, 32'd5,         8'd0,   0, tmi_pkg::STAT_OK},    // wrapped
        '{tmi_pkg::MODE_QUERY,  32'd3,         8'd0,   0, tmi_pkg::STAT_OK},    // unsorted
        '{tmi_pkg::MODE_QUERY,  32'h7FFF_FFFF, 8'd0,   0, tmi_pkg::STAT_OK}
    };

    task automatic run_random();
        logic [31:0] t;
        int          k;
        // mostly well-formed maps: rising times, signature changes, queries
        t = $urandom_range(0, 5000);
        for (k = 0; k < 1700; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1:       send(tmi_pkg::MODE_SIG, $urandom, ($urandom_range(0, 3) == 0)
                                 ? 8'($urandom) : 8'(1 << $urandom_range(0, 7)));
                2:          send(MODE_UNUSED, $urandom, 8'($urandom));
                3:          send(tmi_pkg::MODE_MARKER, $urandom, 8'($urandom));   // noise
                4, 5, 6, 7, 8, 9:
                begin
                    t = t + (($urandom_range(0, 9) == 0) ? 0 :
                             ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 2000));
                    send(tmi_pkg::MODE_MARKER, t, 8'($urandom));
                end
                default:
                begin
                    if ($urandom_range(0, 4) == 0 || map_count < 2)
                        send(tmi_pkg::MODE_QUERY, $urandom, 8'($urandom));
                    else
                        send(tmi_pkg::MODE_QUERY, map_time[$urandom_range(0, map_count - 2)]
                             + $urandom_range(0, 2000), 8'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        int i;
        errors = 0; sent = 0; hold_long = 0;
        map_count = 0; cur_den = tmi_pkg::DEN_RESET; den_last = tmi_pkg::DEN_RESET;
        run_pos = '0;
        item.valid = 1'b0; item.mode = tmi_pkg::MODE_SIG; item.time_ms = '0;
        item.denominator = '0;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed table; typed status checks ride alongside the model check
        for (i = 0; i < N_ROWS; i++)
        begin
            send(dir_rows[i].mode, dir_rows[i].ms, dir_rows[i].den);
            if (dir_rows[i].has_exp && answers_due.size() != 0
                && answers_due[$].status != dir_rows[i].exp_status)
            begin
                $display("%0t: row %0d status expected %0d model %0d", $time, i,
                         dir_rows[i].exp_status, answers_due[$].status);
                errors++;
            end
        end
        // long receiver hold while requests keep coming; receiver ends it
        hold_long = 1'b1;
        for (i = 0; i < 12; i++)
            send(tmi_pkg::MODE_QUERY, 32'd1200 + i, 8'd0);
        run_random();
        item.valid <= 1'b0;
        // wait for the tail, then let any in-flight work settle
        while (answers_due.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off counted here.
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                result.ready <= 1'b0;
                for (n = 0; n < 3000; n++) @(negedge clk);
                hold_long = 1'b0;
            end
            n = $urandom_range(0, 19);
            result.ready <= (n < 12) ? 1'b1 : 1'b0;
            if (n == 19)
            begin
                repeat ($urandom_range(20, 300)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && result.valid && result.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d tick %0d rate %0d status %0d",
                         $time, result.kind, result.tick, result.tempo_rate, result.status);
                errors++;
            end
            else
            begin
                exp_a = answers_due.pop_front();
                if (exp_a.kind !== result.kind || exp_a.tick !== result.tick
                    || exp_a.rate !== result.tempo_rate || exp_a.status !== result.status)
                begin
                    $display("%0t: mismatch expected kind %0d tick %0d rate %0d status %0d",
                             $time, exp_a.kind, exp_a.tick, exp_a.rate, exp_a.status);
                    $display("%0t:          actual   kind %0d tick %0d rate %0d status %0d",
                             $time, result.kind, result.tick, result.tempo_rate,
                             result.status);
                    errors++;
                end
            end
        end
    end

endmodule
